// ===== hw/rtl/jfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfd_pkg: shared types and constants of the joystick frame deframer
// Command and status structs between controller and datapath, frame codes,
// axis select codes and register indexes.
// ----------------------------------------------------------------------------
package jfd_pkg;

    localparam int DATA_BYTES_DEF = 9;

    localparam logic [7:0]  HEADER_BYTE = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE   = 8'hA5;
    localparam logic [15:0] CENTRE      = 16'd2048;
    localparam logic [11:0] MAG_MAX     = 12'd2048;

    localparam int GAIN_W = 14;
    localparam int AXIS_W = 15;
    localparam int SQ_W   = 23;
    localparam int PROD_W = SQ_W + GAIN_W;
    localparam int SHIFT  = 22;

    localparam logic [GAIN_W-1:0] GAIN_XY_RESET  = 14'd6000;
    localparam logic [GAIN_W-1:0] GAIN_ROT_RESET = 14'd800;

    localparam logic CFG_GAIN_XY  = 1'b0;
    localparam logic CFG_GAIN_ROT = 1'b1;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_ROT = 2'd2;

    typedef struct packed {
        logic       sum_init;
        logic       data_wr;
        logic       sel_en;
        logic       sq_en;
        logic       gain_en;
        logic       wr_en;
        logic [1:0] axis_sel;
    } jfd_cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic tail_match;
        logic sum_match;
        logic last_data;
    } jfd_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jfd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfd_datapath: frame storage, checksum and axis mapping
// Holds the data bytes, the running sum and the gains, and runs the shared
// saturate / square / gain / scale chain one axis at a time.
// ----------------------------------------------------------------------------
module jfd_datapath import jfd_pkg::*; #(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jfd_cmd_t          cmd,
    output jfd_sts_t               sts,
    input  wire logic [7:0]        byte_in,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data,
    output logic [AXIS_W-1:0]      axis_x,
    output logic [AXIS_W-1:0]      axis_y,
    output logic [AXIS_W-1:0]      axis_rot,
    output logic [7:0]             button_code
);

    localparam int IDX_W = $clog2(DATA_BYTES);

    logic [7:0]        frame_reg [DATA_BYTES];
    logic [IDX_W-1:0]  ptr_reg;
    logic [7:0]        sum_reg;
    logic [GAIN_W-1:0] gain_xy_reg;
    logic [GAIN_W-1:0] gain_rot_reg;

    logic [11:0]       mag_reg;
    logic              neg_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [AXIS_W-1:0] axis_x_reg;
    logic [AXIS_W-1:0] axis_y_reg;
    logic [AXIS_W-1:0] axis_rot_reg;
    logic [7:0]        button_reg;

    logic [15:0]       raw;
    logic [15:0]       diff;
    logic [11:0]       mag_next;
    logic              neg_next;
    logic [GAIN_W-1:0] gain_sel;
    logic [AXIS_W-1:0] q;
    logic [AXIS_W-1:0] res_next;

    assign sts.hdr_match  = (byte_in == HEADER_BYTE);
    assign sts.tail_match = (byte_in == TAIL_BYTE);
    assign sts.sum_match  = (byte_in == sum_reg);
    assign sts.last_data  = (ptr_reg == IDX_W'(DATA_BYTES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_xy_reg  <= GAIN_XY_RESET;
            gain_rot_reg <= GAIN_ROT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAIN_XY:  gain_xy_reg  <= cfg_data;
                CFG_GAIN_ROT: gain_rot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_init) begin
            sum_reg <= HEADER_BYTE;
            ptr_reg <= '0;
        end else if (cmd.data_wr) begin
            frame_reg[ptr_reg] <= byte_in;
            sum_reg            <= sum_reg + byte_in;
            ptr_reg            <= ptr_reg + 1'b1;
        end
    end

    // stage 1: centre, saturate, sign
    always_comb begin
        unique case (cmd.axis_sel)
            AXIS_X:   raw = {frame_reg[6], frame_reg[7]};
            AXIS_Y:   raw = {frame_reg[4], frame_reg[5]};
            AXIS_ROT: raw = {frame_reg[2], frame_reg[3]};
            default:  raw = CENTRE;
        endcase
        diff = raw - CENTRE;
        if (raw < CENTRE) begin
            mag_next = 12'(CENTRE - raw);
        end else if (diff > CENTRE) begin
            mag_next = MAG_MAX;
        end else begin
            mag_next = diff[11:0];
        end
        neg_next = (raw < CENTRE) ^ (cmd.axis_sel == AXIS_ROT);
    end

    assign gain_sel = (cmd.axis_sel == AXIS_ROT) ? gain_rot_reg : gain_xy_reg;
    assign q        = prod_reg[SHIFT +: AXIS_W];
    assign res_next = neg_reg ? AXIS_W'(~q + 1'b1) : q;

    always_ff @(posedge aclk) begin
        if (cmd.sel_en) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.sq_en) begin
            sq_reg <= SQ_W'({12'd0, mag_reg} * {12'd0, mag_reg});
        end
        if (cmd.gain_en) begin
            prod_reg <= {{GAIN_W{1'b0}}, sq_reg} * {{SQ_W{1'b0}}, gain_sel};
        end
        if (cmd.wr_en) begin
            unique case (cmd.axis_sel)
                AXIS_X:   axis_x_reg <= res_next;
                AXIS_Y:   axis_y_reg <= res_next;
                AXIS_ROT: begin
                    axis_rot_reg <= res_next;
                    button_reg   <= frame_reg[8];
                end
                default: ;
            endcase
        end
    end

    assign axis_x      = axis_x_reg;
    assign axis_y      = axis_y_reg;
    assign axis_rot    = axis_rot_reg;
    assign button_code = button_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/jfd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfd_ctrl: frame parser and mapping sequencer
// Tracks the frame phase, drives the datapath and steps the three axes
// through the shared mapping chain after a good tail.
// ----------------------------------------------------------------------------
module jfd_ctrl import jfd_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire jfd_sts_t sts,
    output jfd_cmd_t      cmd
);

    localparam logic [2:0] ST_SEARCH = 3'd0;
    localparam logic [2:0] ST_DATA   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_SEL    = 3'd4;
    localparam logic [2:0] ST_SQ     = 3'd5;
    localparam logic [2:0] ST_GAIN   = 3'd6;
    localparam logic [2:0] ST_WR     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       acc;

    always_comb begin
        unique case (state_reg) inside
            ST_SEARCH, ST_DATA, ST_CHECK: s_tready = 1'b1;
            ST_TAIL:                      s_tready = !out_valid_reg;
            default:                      s_tready = 1'b0;
        endcase
    end

    assign acc = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.axis_sel   = axis_reg;
        unique case (state_reg)
            ST_SEARCH: begin
                if (acc && sts.hdr_match) begin
                    cmd.sum_init = 1'b1;
                    state_next   = ST_DATA;
                end
            end
            ST_DATA: begin
                if (acc) begin
                    cmd.data_wr = 1'b1;
                    if (sts.last_data) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (acc) begin
                    state_next = sts.sum_match ? ST_TAIL : ST_SEARCH;
                end
            end
            ST_TAIL: begin
                if (acc) begin
                    axis_next  = AXIS_X;
                    state_next = sts.tail_match ? ST_SEL : ST_SEARCH;
                end
            end
            ST_SEL: begin
                cmd.sel_en = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_en  = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain_en = 1'b1;
                state_next  = ST_WR;
            end
            ST_WR: begin
                cmd.wr_en = 1'b1;
                if (axis_reg == AXIS_ROT) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_SEARCH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SEL;
                end
            end
            default: state_next = ST_SEARCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SEARCH;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_rise_from_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WR)
        else $error("result raised outside the write step");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL || state_reg == ST_SQ || state_reg == ST_GAIN)
        |-> !out_valid_reg)
        else $error("mapping runs while a result is pending");

    a_bad_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && state_reg == ST_CHECK && !sts.sum_match) |=> state_reg == ST_SEARCH)
        else $error("bad checksum did not restart search");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> (axis_reg == AXIS_X || axis_reg == AXIS_Y
                                   || axis_reg == AXIS_ROT))
        else $error("axis counter out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/joystick_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_frame_deframer: remote-control frame parser and stick mapper
// Finds 0x5A / data / sum / 0xA5 frames in a byte stream and emits the
// three mapped stick axes and the button code of every good frame.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                     handshake
//  s_        in    tdata[7:0] byte_in                          tvalid/tready
//  m_        out   tdata[55:0] axis_x,axis_y,axis_rot,button   tvalid/tready
//  cfg_      in    index 0 gain_xy, 1 gain_rot (14 bit)        write enable
//
//  Each byte is taken when s_tvalid and s_tready are both high.
//  A good tail starts the mapping (3 axes x 4 steps, select, square, gain and
//  write, through the one saturate/square/gain chain); no byte is taken meanwhile.
//  The tail byte waits while the previous result has not been taken.
//  Reset: header search, gains 6000 and 800.
// ----------------------------------------------------------------------------
module joystick_frame_deframer import jfd_pkg::*; #(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] byte_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [14:0] axis_x, [29:15] axis_y, [44:30] axis_rot, [52:45] button_code, [55:53] 0
    output logic [55:0]            m_tdata,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data
);

    jfd_cmd_t          cmd;
    jfd_sts_t          sts;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_rot;
    logic [7:0]        button_code;

    jfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jfd_datapath #(
        .DATA_BYTES (DATA_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .byte_in     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_rot    (axis_rot),
        .button_code (button_code)
    );

    assign m_tdata = {3'b000, button_code, axis_rot, axis_y, axis_x};

endmodule
`default_nettype wire

// ===== dv/jfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_checker: frame parser predictor and result comparator
// Watches the byte stream, the result stream and the register writes of the
// joystick frame deframer, rebuilds every good frame, maps its sticks and
// compares each result taken field by field with the oldest mapped frame.
// ----------------------------------------------------------------------------
module jfd_checker import jfd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [55:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [GAIN_W-1:0] cfg_data,
    output int                n_pending,
    output int                n_fail
);

    localparam int NDATA = DATA_BYTES_DEF;

    typedef enum logic [1:0] {HUNT, BODY, CHECK, TRAIL} parse_phase_e;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] rot;
        logic [7:0]               btn;
    } mapped_frame_t;

    parse_phase_e      phase_q;
    int                idx_q;
    logic [7:0]        sum_q;
    logic [7:0]        body_q [NDATA];
    logic [GAIN_W-1:0] gain_xy_q;
    logic [GAIN_W-1:0] gain_rot_q;
    mapped_frame_t     expected_frames [$];
    mapped_frame_t     want;

    // sign(d) * min(|d|, 2048)^2 * gain / 2048^2, truncated toward zero
    function automatic logic [AXIS_W-1:0] stick_curve(input int defl,
                                                      input logic [GAIN_W-1:0] gain);
        longint mag;
        longint m;
        m = (defl < 0) ? -longint'(defl) : longint'(defl);
        if (m > longint'(CENTRE))
            m = longint'(CENTRE);
        mag = (m * m * longint'(gain)) / (longint'(CENTRE) * longint'(CENTRE));
        if (defl < 0)
            mag = -mag;
        return mag[AXIS_W-1:0];
    endfunction

    // big-endian stick word, data byte hi (1-based) holds the upper half
    function automatic int stick_at(input int hi);
        return int'({body_q[hi-1], body_q[hi]});
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_q    = HUNT;
            idx_q      = 0;
            sum_q      = '0;
            gain_xy_q  = GAIN_XY_RESET;
            gain_rot_q = GAIN_ROT_RESET;
            foreach (body_q[i])
                body_q[i] = '0;
            expected_frames.delete();
            n_fail     = 0;
            n_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_GAIN_XY)
                    gain_xy_q = cfg_data;
                else
                    gain_rot_q = cfg_data;
            end

            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $error("result with no frame pending: tdata %h", m_tdata);
                    n_fail++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("axis_x", want.x, $signed(m_tdata[14:0]));
                    check_field("axis_y", want.y, $signed(m_tdata[29:15]));
                    check_field("axis_rot", want.rot, $signed(m_tdata[44:30]));
                    check_field("button_code", want.btn, m_tdata[52:45]);
                end
            end

            if (s_tvalid && s_tready) begin
                case (phase_q)
                    HUNT: begin
                        if (s_tdata == HEADER_BYTE) begin
                            phase_q = BODY;
                            idx_q   = 1;
                            sum_q   = HEADER_BYTE;
                        end
                    end
                    BODY: begin
                        body_q[idx_q-1] = s_tdata;
                        sum_q           = sum_q + s_tdata;
                        idx_q++;
                        if (idx_q > NDATA)
                            phase_q = CHECK;
                    end
                    CHECK: begin
                        if (s_tdata == sum_q)
                            phase_q = TRAIL;
                        else
                            phase_q = HUNT;
                    end
                    default: begin
                        phase_q = HUNT;
                        if (s_tdata == TAIL_BYTE) begin
                            want.x   = stick_curve(stick_at(7) - int'(CENTRE), gain_xy_q);
                            want.y   = stick_curve(stick_at(5) - int'(CENTRE), gain_xy_q);
                            want.rot = stick_curve(int'(CENTRE) - stick_at(3), gain_rot_q);
                            want.btn = body_q[8];
                            expected_frames.push_back(want);
                        end
                    end
                endcase
            end

            n_pending <= expected_frames.size();
        end
    end

endmodule

// ===== dv/tb_joystick_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_frame_deframer: stimulus and verdict for the frame deframer
// Feeds good, corrupted and cut frames mixed with line noise in bursts,
// stalls the result side, steps the stick gains through their extremes and
// random values between traffic phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_joystick_frame_deframer;
    import jfd_pkg::*;

    localparam int NDATA = DATA_BYTES_DEF;

    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_TAIL, FLAW_CUT} frame_flaw_e;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [55:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [GAIN_W-1:0] cfg_data  = '0;

    int n_pending;
    int n_fail;
    int burst_left       = 0;
    int frame_bytes_sent = 0;
    int rx_mode          = 0;
    int rx_left          = 0;

    logic [GAIN_W-1:0] xy_set  [5] = '{14'h3FFF, 14'd0, 14'd1, 14'h3FFF, 14'd0};
    logic [GAIN_W-1:0] rot_set [5] = '{14'h3FFF, 14'd0, 14'h3FFF, 14'd0, 14'd1};

    initial begin
        forever #6 aclk = ~aclk;
    end

    joystick_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jfd_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_pending (n_pending),
        .n_fail    (n_fail)
    );

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: free-running, random, sparse and long-stall stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left   = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 120);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= (rx_left < 4);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold the input side until every mapped frame has been taken
    task automatic drain();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [GAIN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_frame(input logic [15:0] rot_raw, input logic [15:0] y_raw,
                              input logic [15:0] x_raw, input logic [7:0] btn,
                              input frame_flaw_e flaw, input logic [7:0] bad);
        logic [7:0] body [NDATA];
        logic [7:0] csum;
        int         keep;
        body[0] = 8'($urandom);
        body[1] = 8'($urandom);
        body[2] = rot_raw[15:8];
        body[3] = rot_raw[7:0];
        body[4] = y_raw[15:8];
        body[5] = y_raw[7:0];
        body[6] = x_raw[15:8];
        body[7] = x_raw[7:0];
        body[8] = btn;
        csum = HEADER_BYTE;
        foreach (body[i])
            csum = csum + body[i];
        keep = (flaw == FLAW_CUT) ? $urandom_range(0, NDATA - 1) : NDATA;
        send_byte(HEADER_BYTE);
        for (int i = 0; i < keep; i++)
            send_byte(body[i]);
        frame_bytes_sent += 1 + keep;
        if (flaw == FLAW_CUT)
            return;
        if (flaw == FLAW_SUM) begin
            send_byte((bad == csum) ? ~csum : bad);
            frame_bytes_sent++;
            return;
        end
        send_byte(csum);
        if (flaw == FLAW_TAIL)
            send_byte((bad == TAIL_BYTE) ? ~TAIL_BYTE : bad);
        else
            send_byte(TAIL_BYTE);
        frame_bytes_sent += 2;
    endtask

    function automatic logic [15:0] pick_stick();
        logic [15:0] corner_vals [9] = '{16'd0, 16'd1, 16'd2047, 16'd2048, 16'd2049,
                                          16'd4095, 16'd4096, 16'd4097, 16'hFFFF};
        case ($urandom_range(0, 7))
            0:       return corner_vals[$urandom_range(0, 8)];
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic run_traffic(input int quota);
        int          stop_at;
        int          pick;
        frame_flaw_e flaw;
        stop_at = frame_bytes_sent + quota;
        // full deflection on every axis under the new gains
        send_frame(16'h0000, 16'hFFFF, 16'h0000, 8'($urandom), FLAW_NONE, 8'h00);
        while (frame_bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                drain();
            if (pick < 12) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    flaw = FLAW_NONE;
                else if (pick < 87)
                    flaw = FLAW_SUM;
                else if (pick < 94)
                    flaw = FLAW_TAIL;
                else
                    flaw = FLAW_CUT;
                send_frame(pick_stick(), pick_stick(), pick_stick(), 8'($urandom),
                           flaw, 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise in search, saturated rot and y sticks with x centred, then a bad sum that looks like a header
        send_byte(8'h00);
        send_frame(16'h0000, 16'hFFFF, 16'h0800, 8'hFF, FLAW_NONE, 8'h00);
        send_frame(16'h1000, 16'h0001, 16'h07FF, 8'h00, FLAW_SUM, HEADER_BYTE);
        drain();

        run_traffic(160);
        drain();

        for (int k = 0; k < 7; k++) begin
            if (k < 5) begin
                write_cfg(CFG_GAIN_XY, xy_set[k]);
                write_cfg(CFG_GAIN_ROT, rot_set[k]);
            end else begin
                write_cfg(CFG_GAIN_XY, 14'($urandom));
                write_cfg(CFG_GAIN_ROT, 14'($urandom));
            end
            run_traffic(160);
            drain();
        end

        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
